[design/tmwf_pkg.sv]
package tmwf_pkg;

    // fixed field widths of the channels
    localparam int IN_W  = 10;
    localparam int OUT_W = 10;

    // default build parameters
    localparam int DEF_WINDOW_SIZE = 8;
    localparam int DEF_SAMPLE_BITS = 10;

    // trim percentages
    localparam int PCT_LO  = 25;
    localparam int PCT_HI  = 75;
    localparam int PCT_DEN = 100;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANK,
        ST_DIV_INIT,
        ST_DIV,
        ST_HOLD
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic write;
        logic rank_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic rank_last;
        logic out_free;
    } t_sts;

endpackage

[design/tmwf_ifs.sv]
interface tmwf_sample_if
    import tmwf_pkg::*;
    (input logic i_clk);
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface tmwf_smoothed_if
    import tmwf_pkg::*;
    (input logic i_clk);
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] smoothed;

    modport source (output valid, output smoothed, input ready);
    modport sink (input valid, input smoothed, output ready);
endinterface

[design/tmwf_ctrl.sv]
module tmwf_ctrl
    import tmwf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RANK;
                end
            end
            ST_RANK: begin
                if (i_sts.rank_last) begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.write = i_in_valid;
            end
            ST_RANK: begin
                o_cmd.rank_step = 1'b1;
            end
            ST_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_HOLD: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/tmwf_dp.sv]
module tmwf_dp
    import tmwf_pkg::*;
#(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [IN_W-1:0]  i_sample,
    input  logic             i_out_ready,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output logic [OUT_W-1:0] o_smoothed
);

    // trim bounds
    localparam int LO_CAND = (WINDOW_SIZE * PCT_LO) / PCT_DEN;
    localparam int LO_RANK = (LO_CAND > 1) ? LO_CAND : 1;
    localparam int HI_CAND = (WINDOW_SIZE * PCT_HI) / PCT_DEN + 1;
    localparam int HI_RANK = (HI_CAND < WINDOW_SIZE - 1) ? HI_CAND : WINDOW_SIZE - 1;
    localparam int KEEP    = HI_RANK - LO_RANK;

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_SIZE);

    // exact floor division by the kept count through a reciprocal multiply
    localparam int     RCP_SH  = $clog2(KEEP);
    localparam int     MUL_W   = SUM_W + 1;
    localparam int     PROD_W  = SUM_W + MUL_W;
    localparam int     SHIFT   = SUM_W + RCP_SH;
    localparam int     QUO_W   = PROD_W - SHIFT;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(KEEP - 1))
                                 / longint'(KEEP);

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [IDX_W-1:0]  LO_R     = IDX_W'(LO_RANK);
    localparam logic [IDX_W-1:0]  HI_R     = IDX_W'(HI_RANK);
    localparam logic [PROD_W-1:0] RECIP    = PROD_W'(RECIP_L);

    logic [SAMPLE_BITS-1:0] r_win [WINDOW_SIZE];
    logic [IDX_W-1:0]       r_slot;
    logic [IDX_W-1:0]       n_slot;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_out_valid;
    logic [SUM_W-1:0]       r_acc;
    logic [PROD_W-1:0]      r_prod;
    logic [QUO_W-1:0]       r_quo;
    logic [OUT_W-1:0]       r_smoothed;

    logic [SAMPLE_BITS-1:0] cur_val;
    logic [IDX_W-1:0]       cur_rank;
    logic                   cur_kept;

    // next write slot of the ring
    always_comb begin
        n_slot = (r_slot == LAST_IDX) ? '0 : r_slot + 1'b1;
    end

    // stable rank of the current entry among the window
    always_comb begin
        cur_val  = r_win[r_idx];
        cur_rank = '0;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            if ((r_win[j] < cur_val) || ((r_win[j] == cur_val) && (IDX_W'(j) < r_idx))) begin
                cur_rank = cur_rank + 1'b1;
            end
        end
        cur_kept = (cur_rank >= LO_R) && (cur_rank < HI_R);
    end

    // window, pointers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_SIZE; k++) begin
                r_win[k] <= '0;
            end
            r_slot      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_win[n_slot] <= SAMPLE_BITS'(i_sample);
                r_slot        <= n_slot;
                r_idx         <= '0;
            end else if (i_cmd.rank_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sum, reciprocal multiply and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_acc <= '0;
        end else if (i_cmd.rank_step && cur_kept) begin
            r_acc <= r_acc + SUM_W'(cur_val);
        end
        if (i_cmd.div_start) begin
            r_prod <= PROD_W'(r_acc) * RECIP;
        end
        if (i_cmd.div_step) begin
            r_quo <= r_prod[PROD_W-1:SHIFT];
        end
        if (i_cmd.load_out) begin
            r_smoothed <= OUT_W'(r_quo);
        end
    end

    assign o_sts.rank_last = (r_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_smoothed      = r_smoothed;

endmodule

[design/trimmed_mean_window_filter_core.sv]
// channel   dir  payload           request moves when
// i_in      in   sample   [9:0]    valid && ready
// o_out     out  smoothed [9:0]    valid && ready
//
// one request at a time, worked through the per-entry rank scan
// and then the reciprocal multiply (ST_DIV_INIT, then ST_DIV)
// the result sits in an output register; the next request is taken once it is loaded
// a result that is not taken holds the block before that load
// reset (i_rst_n low, synchronous) zeroes the window and the write slot
module trimmed_mean_window_filter_core
    import tmwf_pkg::*;
#(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tmwf_sample_if.sink      i_in,
    tmwf_smoothed_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    logic [OUT_W-1:0] smoothed;

    // sequencing
    tmwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // window, rank scan and divider
    tmwf_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (i_in.sample),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_smoothed  (smoothed)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.smoothed = smoothed;

endmodule

[design/tmwf_checker.sv]
module tmwf_checker
    import tmwf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_smoothed
);

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one request in flight: the input side stays busy after a take
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("request taken while busy");

    // a new result is only loaded while the input side is closed
    a_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result loaded while idle");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_smoothed)))
        else $error("stalled result changed");

endmodule

bind trimmed_mean_window_filter_core tmwf_checker u_tmwf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_smoothed  (o_out.smoothed)
);

[verif/trimmed_mean_window_filter_core_tb.sv]
module trimmed_mean_window_filter_core_tb;
    import tmwf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN   = DEF_WINDOW_SIZE;
    localparam int SBITS = DEF_SAMPLE_BITS;
    localparam int SLOT_W = $clog2(WIN);

    // kept rank range of the ordered window
    localparam int LO_CAND = (WIN * PCT_LO) / PCT_DEN;
    localparam int LO_RANK = (LO_CAND > 1) ? LO_CAND : 1;
    localparam int HI_CAND = ((WIN * PCT_HI) / PCT_DEN) + 1;
    localparam int HI_RANK = (HI_CAND < (WIN - 1)) ? HI_CAND : (WIN - 1);

    // cycles for one request through rank scan and reciprocal multiply
    localparam int LAT         = WIN + 4;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int N_RAND      = 1650;
    localparam int SAMPLE_MAX  = (1 << IN_W) - 1;

    // one row of the directed table
    typedef struct packed {
        logic [IN_W-1:0]  sample;
        logic             typed;
        logic [OUT_W-1:0] want;
    } t_stim_row;

    localparam int N_DIR = 24;
    localparam t_stim_row DIR_TAB [N_DIR] = '{
        // fill with full scale: reset zeros dominate, then the window saturates
        '{10'd1023, 1'b1, 10'd0},
        '{10'd1023, 1'b0, 10'd0},
        '{10'd1023, 1'b0, 10'd0},
        '{10'd1023, 1'b0, 10'd0},
        '{10'd1023, 1'b0, 10'd0},
        '{10'd1023, 1'b1, 10'd1023},
        '{10'd1023, 1'b1, 10'd1023},
        '{10'd1023, 1'b1, 10'd1023},
        // zeros pushed in: the first two fall in the trimmed low ranks
        '{10'd0,    1'b1, 10'd1023},
        '{10'd0,    1'b1, 10'd1023},
        '{10'd0,    1'b0, 10'd0},
        '{10'd0,    1'b0, 10'd0},
        '{10'd0,    1'b0, 10'd0},
        '{10'd0,    1'b0, 10'd0},
        '{10'd0,    1'b1, 10'd0},
        '{10'd0,    1'b1, 10'd0},
        // lone spike is trimmed away
        '{10'd1023, 1'b1, 10'd0},
        '{10'd0,    1'b1, 10'd0},
        '{10'd1,    1'b0, 10'd0},
        '{10'd2,    1'b0, 10'd0},
        '{10'd512,  1'b0, 10'd0},
        '{10'd511,  1'b0, 10'd0},
        '{10'd1023, 1'b0, 10'd0},
        '{10'd1023, 1'b0, 10'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tmwf_sample_if   u_in_if  (.i_clk(i_clk));
    tmwf_smoothed_if u_out_if (.i_clk(i_clk));

    trimmed_mean_window_filter_core #(
        .WINDOW_SIZE(WIN),
        .SAMPLE_BITS(SBITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    // predictor state
    logic [SBITS-1:0]  window_q [WIN];
    logic [SLOT_W-1:0] slot_q;

    logic [OUT_W-1:0] smoothed_q [$];
    logic [OUT_W-1:0] want_v;
    int               mismatch_cnt = 0;
    int               idle_cnt     = 0;

    // receiver control
    logic hold_off_req = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   stall_mode   = 0;
    int   stall_left   = 0;
    int   tick         = 0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // write the new sample into the window and work out the trimmed mean
    task automatic advance_window(input logic [IN_W-1:0] s, output logic [OUT_W-1:0] mean);
        int ordered [WIN];
        int a;
        int b;
        int v;
        int total;
        int cnt;
        slot_q = SLOT_W'((int'(slot_q) + 1) % WIN);
        window_q[slot_q] = s[SBITS-1:0];
        for (a = 0; a < WIN; a++) begin
            v = int'(window_q[a]);
            b = a;
            while (b > 0 && ordered[b-1] > v) begin
                ordered[b] = ordered[b-1];
                b--;
            end
            ordered[b] = v;
        end
        total = 0;
        cnt = 0;
        for (a = LO_RANK; a < HI_RANK; a++) begin
            total += ordered[a];
            cnt++;
        end
        mean = (cnt != 0) ? OUT_W'(total / cnt) : '0;
    endtask

    // offer one request and record its expected result once accepted
    task automatic offer_item(input logic [IN_W-1:0] s, input logic typed,
                              input logic [OUT_W-1:0] want);
        logic [OUT_W-1:0] m;
        u_in_if.valid  <= 1'b1;
        u_in_if.sample <= s;
        @(posedge i_clk);
        while (!u_in_if.ready) @(posedge i_clk);
        advance_window(s, m);
        smoothed_q.push_back(typed ? want : m);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            u_in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [IN_W-1:0] clamp_sample(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > SAMPLE_MAX) begin
            return IN_W'(SAMPLE_MAX);
        end
        return IN_W'(v);
    endfunction

    // sample shapes: uniform, noisy level, level with spikes, rail values
    function automatic logic [IN_W-1:0] pick_sample(input int mode, input int level);
        case (mode)
            0: begin
                return IN_W'($urandom_range(0, SAMPLE_MAX));
            end
            1: begin
                return clamp_sample(level + int'($urandom_range(0, 16)) - 8);
            end
            2: begin
                if ($urandom_range(0, 5) == 0) begin
                    return $urandom_range(0, 1) ? IN_W'(SAMPLE_MAX) : '0;
                end
                return clamp_sample(level + int'($urandom_range(0, 32)) - 16);
            end
            default: begin
                if ($urandom_range(0, 1) != 0) begin
                    return IN_W'(SAMPLE_MAX - int'($urandom_range(0, 3)));
                end
                return IN_W'($urandom_range(0, 3));
            end
        endcase
    endfunction

    // sender
    initial begin
        int i;
        int sent;
        int burst_len;
        int mode;
        int level;
        int k;
        u_in_if.valid  = 1'b0;
        u_in_if.sample = '0;
        for (i = 0; i < WIN; i++) begin
            window_q[i] = '0;
        end
        slot_q = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (i = 0; i < N_DIR; i++) begin
            offer_item(DIR_TAB[i].sample, DIR_TAB[i].typed, DIR_TAB[i].want);
            if ($urandom_range(0, 3) == 0) begin
                idle_for($urandom_range(1, 5));
            end
        end

        // random bursts
        sent = 0;
        while (sent < N_RAND) begin
            burst_len = $urandom_range(1, 48);
            mode      = $urandom_range(0, 3);
            level     = $urandom_range(0, SAMPLE_MAX);
            for (k = 0; k < burst_len && sent < N_RAND; k++) begin
                offer_item(pick_sample(mode, level), 1'b0, '0);
                sent++;
                // long receiver hold while requests keep coming
                if (sent == N_RAND / 3) begin
                    hold_off_req <= 1'b1;
                end
                // let the block drain completely
                if (sent == (2 * N_RAND) / 3) begin
                    u_in_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (smoothed_q.size() != 0) @(posedge i_clk);
                    repeat (LAT) @(posedge i_clk);
                end
            end
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        end
        u_in_if.valid <= 1'b0;

        // wait for the tail
        while (smoothed_q.size() != 0) @(posedge i_clk);
        repeat (LAT * 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && smoothed_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // receiver stall pattern with one long hold
    initial u_out_if.ready = 1'b0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            u_out_if.ready <= 1'b0;
        end else if (hold_off_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            u_out_if.ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(16, 128);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: begin
                    u_out_if.ready <= 1'b1;
                end
                1: begin
                    u_out_if.ready <= (tick % 3 == 0);
                end
                2: begin
                    u_out_if.ready <= ($urandom_range(0, 1) != 0);
                end
                default: begin
                    u_out_if.ready <= ($urandom_range(0, 9) != 0);
                end
            endcase
            tick <= tick + 1;
        end
    end

    // compare each result with the oldest expected value
    always @(posedge i_clk) begin
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            if (smoothed_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected result smoothed=%0d", u_out_if.smoothed);
                end
            end else begin
                want_v = smoothed_q.pop_front();
                if (u_out_if.smoothed !== want_v) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("smoothed mismatch: expected %0d, got %0d",
                                 want_v, u_out_if.smoothed);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((u_in_if.valid && u_in_if.ready) || (u_out_if.valid && u_out_if.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
